@@ sv/rlhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlhc_pkg
// shared types and constants of the refcounted lru handle cache
// ----------------------------------------------------------------------------
`default_nettype none

package rlhc_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;
  localparam logic [15:0] RC_MAX  = 16'hFFFF;

  // register select values, compared with paddr[2]
  localparam logic REG_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_INSERT   = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_MATCH,
    ST_EVICT_CHK,
    ST_SCAN_LRU,
    ST_SHIFT,
    ST_APPEND
  } state_e;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] buffer;
    logic [7:0]  ctx;
    logic [31:0] handle;
    logic [15:0] refcnt;
    logic [63:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

@@ sv/refcounted_lru_handle_cache_unit.sv @@
// ----------------------------------------------------------------------------
// refcounted_lru_handle_cache_unit
// fully associative lru cache of registration handles with reference counts
// ----------------------------------------------------------------------------
// sequence: a lookup or complete scans the filled entries before done_o rises; a
//   removal adds a compaction of the later entries, and an lru eviction adds a scan
//   of all filled entries
// throughput: one transaction at a time, the next one is accepted in the cycle that
//   done_o is high; results cannot be stalled by the receiver
// reset: fill count, stamp counter and fsm cleared, entry limit back to 16
`default_nettype none

module refcounted_lru_handle_cache_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // command side
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [63:0] base_addr_i,
  input  wire logic [63:0] buffer_id_i,
  input  wire logic [7:0]  ctx_idx_i,
  input  wire logic [31:0] handle_i,
  input  wire logic        keep_cache_i,
  // result side
  output logic             done_o,
  output logic             hit_o,
  output logic      [31:0] handle_out_o,
  output logic             cached_o,
  output logic             release_valid_o,
  output logic      [31:0] release_handle_o
);

  localparam int unsigned IDX_W = rlhc_pkg::IDX_W;
  localparam int unsigned CNT_W = rlhc_pkg::CNT_W;

  // ---------------------------------------------------------------- config
  logic [rlhc_pkg::LIMIT_W-1:0] limit_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == rlhc_pkg::REG_LIMIT)
                  ? {25'd0, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= rlhc_pkg::LIMIT_RESET;
    end else if (cfg_wr && paddr[2] == rlhc_pkg::REG_LIMIT) begin
      limit_q <= pwdata[rlhc_pkg::LIMIT_W-1:0];
    end
  end

  // effective limit, clipped to the table depth
  logic [CNT_W-1:0] lim;
  assign lim = (32'(limit_q) > 32'(rlhc_pkg::DEPTH)) ? CNT_W'(rlhc_pkg::DEPTH)
                                                     : CNT_W'(limit_q);

  // ---------------------------------------------------------------- memory
  rlhc_pkg::entry_t mem [rlhc_pkg::DEPTH];
  rlhc_pkg::entry_t rdata_q;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  rlhc_pkg::entry_t mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------- state
  rlhc_pkg::state_e state_q, state_d;
  rlhc_pkg::op_e    op_q, op_d;
  logic [63:0]      base_q, base_d;
  logic [63:0]      buf_q, buf_d;
  logic [7:0]       ctx_q, ctx_d;
  logic [31:0]      hdl_q, hdl_d;
  logic             keep_q, keep_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [63:0]      stamp_q, stamp_d;
  // scan pipeline: issue pointer, and index of the read data in flight
  logic [CNT_W-1:0] ia_q, ia_d;
  logic             dv_q, dv_d;
  logic [IDX_W-1:0] di_q, di_d;
  // lru candidate
  logic             have_q, have_d;
  logic [IDX_W-1:0] best_q, best_d;
  logic [63:0]      best_stamp_q, best_stamp_d;
  logic [31:0]      best_handle_q, best_handle_d;
  // result registers
  logic             done_q, done_d;
  logic             hit_q, hit_d;
  logic [31:0]      hout_q, hout_d;
  logic             cached_q, cached_d;
  logic             rv_q, rv_d;
  logic [31:0]      rh_q, rh_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlhc_pkg::ST_IDLE;
      count_q <= '0;
      stamp_q <= '0;
      dv_q    <= 1'b0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      stamp_q <= stamp_d;
      dv_q    <= dv_d;
      have_q  <= have_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    base_q        <= base_d;
    buf_q         <= buf_d;
    ctx_q         <= ctx_d;
    hdl_q         <= hdl_d;
    keep_q        <= keep_d;
    ia_q          <= ia_d;
    di_q          <= di_d;
    best_q        <= best_d;
    best_stamp_q  <= best_stamp_d;
    best_handle_q <= best_handle_d;
    hit_q         <= hit_d;
    hout_q        <= hout_d;
    cached_q      <= cached_d;
    rv_q          <= rv_d;
    rh_q          <= rh_d;
  end

  // ---------------------------------------------------------------- control
  logic             key_eq;
  logic             hdl_eq;
  logic [15:0]      rc_dec;
  rlhc_pkg::entry_t upd;

  assign key_eq = (rdata_q.base == base_q) && (rdata_q.ctx == ctx_q) &&
                  (rdata_q.buffer == buf_q);
  assign hdl_eq = (rdata_q.handle == hdl_q);
  assign rc_dec = (rdata_q.refcnt != 16'd0) ? rdata_q.refcnt - 16'd1 : 16'd0;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    base_d        = base_q;
    buf_d         = buf_q;
    ctx_d         = ctx_q;
    hdl_d         = hdl_q;
    keep_d        = keep_q;
    count_d       = count_q;
    stamp_d       = stamp_q;
    ia_d          = ia_q;
    dv_d          = 1'b0;
    di_d          = di_q;
    have_d        = have_q;
    best_d        = best_q;
    best_stamp_d  = best_stamp_q;
    best_handle_d = best_handle_q;
    done_d        = 1'b0;
    hit_d         = hit_q;
    hout_d        = hout_q;
    cached_d      = cached_q;
    rv_d          = rv_q;
    rh_d          = rh_q;
    mem_re        = 1'b0;
    mem_raddr     = ia_q[IDX_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = di_q;
    mem_wdata     = rdata_q;
    upd           = rdata_q;

    // scanning states read one entry per cycle until the fill is reached
    if ((state_q == rlhc_pkg::ST_SCAN_MATCH || state_q == rlhc_pkg::ST_SCAN_LRU ||
         state_q == rlhc_pkg::ST_SHIFT) && ia_q < count_q) begin
      mem_re = 1'b1;
      ia_d   = CNT_W'(ia_q + 1'b1);
      dv_d   = 1'b1;
      di_d   = ia_q[IDX_W-1:0];
    end

    unique case (state_q)
      rlhc_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d     = rlhc_pkg::op_e'(op_i);
          base_d   = base_addr_i;
          buf_d    = buffer_id_i;
          ctx_d    = ctx_idx_i;
          hdl_d    = handle_i;
          keep_d   = keep_cache_i;
          hit_d    = 1'b0;
          hout_d   = '0;
          cached_d = 1'b0;
          rv_d     = 1'b0;
          rh_d     = '0;
          state_d  = rlhc_pkg::ST_DISPATCH;
        end
      end

      rlhc_pkg::ST_DISPATCH: begin
        ia_d = '0;
        unique case (op_q) inside
          rlhc_pkg::OP_LOOKUP, rlhc_pkg::OP_COMPLETE: state_d = rlhc_pkg::ST_SCAN_MATCH;
          rlhc_pkg::OP_INSERT: state_d = rlhc_pkg::ST_EVICT_CHK;
          default: begin
            done_d  = 1'b1;
            state_d = rlhc_pkg::ST_IDLE;
          end
        endcase
      end

      rlhc_pkg::ST_SCAN_MATCH: begin
        if (dv_q && ((op_q == rlhc_pkg::OP_LOOKUP) ? key_eq : hdl_eq)) begin
          dv_d   = 1'b0;
          mem_we = 1'b1;
          hit_d  = 1'b1;
          if (op_q == rlhc_pkg::OP_LOOKUP) begin
            upd.stamp = stamp_q + 64'd1;
            if (rdata_q.refcnt != rlhc_pkg::RC_MAX) begin
              upd.refcnt = rdata_q.refcnt + 16'd1;
            end
            stamp_d = stamp_q + 64'd1;
            hout_d  = rdata_q.handle;
            done_d  = 1'b1;
            state_d = rlhc_pkg::ST_IDLE;
          end else begin
            upd.refcnt = rc_dec;
            if (rc_dec != 16'd0) begin
              done_d  = 1'b1;
              state_d = rlhc_pkg::ST_IDLE;
            end else if (keep_q) begin
              state_d = rlhc_pkg::ST_EVICT_CHK;
            end else begin
              // delete this entry and compact the tail
              rv_d    = 1'b1;
              rh_d    = rdata_q.handle;
              ia_d    = CNT_W'(di_q) + CNT_W'(1);
              state_d = rlhc_pkg::ST_SHIFT;
            end
          end
          mem_wdata = upd;
        end else if (!dv_q && ia_q == count_q) begin
          // nothing found; an unknown complete is released as is
          if (op_q == rlhc_pkg::OP_COMPLETE) begin
            rv_d = 1'b1;
            rh_d = hdl_q;
          end
          done_d  = 1'b1;
          state_d = rlhc_pkg::ST_IDLE;
        end
      end

      rlhc_pkg::ST_EVICT_CHK: begin
        ia_d   = '0;
        have_d = 1'b0;
        if (count_q >= lim) begin
          state_d = rlhc_pkg::ST_SCAN_LRU;
        end else if (op_q == rlhc_pkg::OP_INSERT) begin
          state_d = rlhc_pkg::ST_APPEND;
        end else begin
          done_d  = 1'b1;
          state_d = rlhc_pkg::ST_IDLE;
        end
      end

      rlhc_pkg::ST_SCAN_LRU: begin
        if (dv_q && rdata_q.refcnt == 16'd0 &&
            (!have_q || rdata_q.stamp < best_stamp_q)) begin
          have_d        = 1'b1;
          best_d        = di_q;
          best_stamp_d  = rdata_q.stamp;
          best_handle_d = rdata_q.handle;
        end
        if (!dv_q && ia_q == count_q) begin
          if (have_q) begin
            rv_d    = 1'b1;
            rh_d    = best_handle_q;
            ia_d    = CNT_W'(best_q) + CNT_W'(1);
            state_d = rlhc_pkg::ST_SHIFT;
          end else if (op_q == rlhc_pkg::OP_INSERT) begin
            state_d = rlhc_pkg::ST_APPEND;
          end else begin
            done_d  = 1'b1;
            state_d = rlhc_pkg::ST_IDLE;
          end
        end
      end

      rlhc_pkg::ST_SHIFT: begin
        // move each later entry one slot down
        if (dv_q) begin
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(di_q - 1'b1);
        end
        if (!dv_q && ia_q == count_q) begin
          count_d = CNT_W'(count_q - 1'b1);
          if (op_q == rlhc_pkg::OP_INSERT) begin
            state_d = rlhc_pkg::ST_APPEND;
          end else begin
            done_d  = 1'b1;
            state_d = rlhc_pkg::ST_IDLE;
          end
        end
      end

      rlhc_pkg::ST_APPEND: begin
        if (count_q < lim) begin
          mem_we           = 1'b1;
          mem_waddr        = count_q[IDX_W-1:0];
          mem_wdata.base   = base_q;
          mem_wdata.buffer = buf_q;
          mem_wdata.ctx    = ctx_q;
          mem_wdata.handle = hdl_q;
          mem_wdata.refcnt = 16'd1;
          mem_wdata.stamp  = stamp_q + 64'd1;
          stamp_d          = stamp_q + 64'd1;
          count_d          = CNT_W'(count_q + 1'b1);
          cached_d         = 1'b1;
        end
        done_d  = 1'b1;
        state_d = rlhc_pkg::ST_IDLE;
      end

      default: state_d = rlhc_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  assign busy_o           = (state_q != rlhc_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign hit_o            = hit_q;
  assign handle_out_o     = hout_q;
  assign cached_o         = cached_q;
  assign release_valid_o  = rv_q;
  assign release_handle_o = rh_q;

endmodule

`default_nettype wire

@@ sv/rlhc_checker.sv @@
// ----------------------------------------------------------------------------
// rlhc_checker
// port-level checks of the refcounted lru handle cache
// ----------------------------------------------------------------------------
`default_nettype none

module rlhc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic        hit_o,
  input wire logic [31:0] handle_out_o,
  input wire logic        cached_o,
  input wire logic        release_valid_o,
  input wire logic [31:0] release_handle_o
);

  // an accepted transaction keeps the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accept without busy");

  // one strobe per transaction, never two in a row
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double done");

  // an insert result never also reports a hit
  a_cached_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && cached_o |-> !hit_o) else $error("cached with hit");

  // a returned handle implies a hit
  a_hout_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && handle_out_o != 32'd0 |-> hit_o) else $error("handle without hit");

  // the release handle is zero unless a release is reported
  a_rel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !release_valid_o |-> release_handle_o == 32'd0)
    else $error("stray release handle");

endmodule

bind refcounted_lru_handle_cache_unit rlhc_checker u_rlhc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .hit_o            (hit_o),
  .handle_out_o     (handle_out_o),
  .cached_o         (cached_o),
  .release_valid_o  (release_valid_o),
  .release_handle_o (release_handle_o)
);

`default_nettype wire
